>>> rtl/tpc_pkg.sv
// Package for the triangle plane clipper: widths, codes, payload and stage types.
// Used by every RTL file of the clipper; depends on nothing.
package tpc_pkg;

  // Datapath widths.
  localparam int COORD_W    = 32;
  localparam int FRAC_BITS  = 16;
  localparam int NORM_W     = FRAC_BITS + 2;
  localparam int PROD_W     = COORD_W + NORM_W;
  localparam int DIST_W     = PROD_W + 3;
  localparam int DEN_W      = DIST_W;
  localparam int MAG_W      = COORD_W + 1;
  localparam int REM_W      = DEN_W + 2;
  localparam int LANE_LAT   = MAG_W + 1;
  localparam int COLOR_W    = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Register reset values: plane at z = 0.1, normal along +z.
  localparam logic [COORD_W-1:0] POINT_Z_RST  = COORD_W'(6554);
  localparam logic [NORM_W-1:0]  NORMAL_Z_RST = NORM_W'(65536);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POINT_X  = 3'd0,
    REG_POINT_Y  = 3'd1,
    REG_POINT_Z  = 3'd2,
    REG_NORMAL_X = 3'd3,
    REG_NORMAL_Y = 3'd4,
    REG_NORMAL_Z = 3'd5
  } cfg_reg_t;

  // How many vertices lie inside the plane.
  typedef enum logic [1:0] {
    CLIP_NONE = 2'd0,
    CLIP_ONE  = 2'd1,
    CLIP_TWO  = 2'd2,
    CLIP_ALL  = 2'd3
  } clip_case_t;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [NORM_W-1:0]  norm_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [DIST_W-1:0]  dist_t;
  // Element 0 is x, 1 is y, 2 is z.
  typedef coord_t [2:0] vec_t;
  typedef vec_t [2:0] tri_t;

  typedef struct packed {
    coord_t vert0_x;
    coord_t vert0_y;
    coord_t vert0_z;
    coord_t vert1_x;
    coord_t vert1_y;
    coord_t vert1_z;
    coord_t vert2_x;
    coord_t vert2_y;
    coord_t vert2_z;
    logic [COLOR_W-1:0] tri_color;
  } tri_in_t;

  typedef struct packed {
    coord_t out0_x;
    coord_t out0_y;
    coord_t out0_z;
    coord_t out1_x;
    coord_t out1_y;
    coord_t out1_z;
    coord_t out2_x;
    coord_t out2_y;
    coord_t out2_z;
    logic [COLOR_W-1:0] out_color;
    logic last_of_run;
  } tri_out_t;

  // Operands of one coordinate's crossing computation.
  typedef struct packed {
    coord_t a;
    logic [MAG_W-1:0] mag;
    logic neg;
    logic [DEN_W-1:0] da;
    logic [DEN_W-1:0] den;
  } lane_in_t;

  // Triangle data that travels beside the lanes.
  typedef struct packed {
    clip_case_t ccase;
    tri_t sv;
    logic [COLOR_W-1:0] color;
  } side_t;

  // What reaches the merging stage.
  typedef struct packed {
    logic valid;
    side_t side;
    vec_t xa;
    vec_t xb;
  } merge_in_t;

endpackage

>>> rtl/tpc_lane.sv
// One lane of the clipper: rounded a + (b - a) * da / den for one coordinate.
// Radix-2 long division pipeline, one multiplier bit per stage; uses tpc_pkg.
module tpc_lane (
  input  logic              clk,
  input  logic              en,
  input  tpc_pkg::lane_in_t lane_in,
  output tpc_pkg::coord_t   coord
);

  typedef struct packed {
    logic [tpc_pkg::DEN_W-1:0] rem;
    logic [tpc_pkg::MAG_W-1:0] q;
    logic [tpc_pkg::MAG_W-1:0] mag;
    logic [tpc_pkg::DEN_W-1:0] da;
    logic [tpc_pkg::DEN_W-1:0] den;
    tpc_pkg::coord_t a;
    logic neg;
  } step_t;

  step_t st_r   [tpc_pkg::MAG_W];
  step_t st_nxt [tpc_pkg::MAG_W];
  tpc_pkg::coord_t coord_r;
  tpc_pkg::coord_t coord_nxt;

  // Each stage folds in one bit of mag: t = 2*rem + bit*da, digit 0..2.
  always_comb begin
    step_t src;
    logic [tpc_pkg::REM_W-1:0] t;
    logic [tpc_pkg::REM_W-1:0] den1;
    logic [tpc_pkg::REM_W-1:0] den2;
    logic [1:0] dig;
    for (int k = 0; k < tpc_pkg::MAG_W; k++) begin
      if (k == 0) begin
        src.rem = '0;
        src.q   = '0;
        src.mag = lane_in.mag;
        src.da  = lane_in.da;
        src.den = lane_in.den;
        src.a   = lane_in.a;
        src.neg = lane_in.neg;
      end else begin
        src = st_r[k-1];
      end
      den1 = tpc_pkg::REM_W'(src.den);
      den2 = tpc_pkg::REM_W'({src.den, 1'b0});
      t = tpc_pkg::REM_W'({src.rem, 1'b0}) +
          (src.mag[tpc_pkg::MAG_W-1-k] ? tpc_pkg::REM_W'(src.da) : '0);
      if (t >= den2) begin
        t   = t - den2;
        dig = 2'd2;
      end else if (t >= den1) begin
        t   = t - den1;
        dig = 2'd1;
      end else begin
        dig = 2'd0;
      end
      st_nxt[k]     = src;
      st_nxt[k].rem = tpc_pkg::DEN_W'(t);
      st_nxt[k].q   = tpc_pkg::MAG_W'({src.q, 1'b0}) + tpc_pkg::MAG_W'(dig);
    end
  end

  // Round half away from a, then step from a toward b.
  always_comb begin
    step_t last;
    logic [tpc_pkg::MAG_W:0] qf;
    logic signed [tpc_pkg::COORD_W+2:0] sum;
    last = st_r[tpc_pkg::MAG_W-1];
    qf = (tpc_pkg::MAG_W+1)'(last.q) +
         (tpc_pkg::MAG_W+1)'(tpc_pkg::REM_W'({last.rem, 1'b0}) >=
                             tpc_pkg::REM_W'(last.den));
    if (last.neg) begin
      sum = (tpc_pkg::COORD_W+3)'(last.a) - $signed({1'b0, qf});
    end else begin
      sum = (tpc_pkg::COORD_W+3)'(last.a) + $signed({1'b0, qf});
    end
    coord_nxt = sum[tpc_pkg::COORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < tpc_pkg::MAG_W; k++) begin
        st_r[k] <= st_nxt[k];
      end
      coord_r <= coord_nxt;
    end
  end

  assign coord = coord_r;

endmodule

>>> rtl/tpc_merge.sv
// Merging stage of the clipper: builds the output triangles from the lane results.
// Emits a quad as two transactions and holds the pipeline meanwhile; uses tpc_pkg.
module tpc_merge (
  input  logic               clk,
  input  logic               rst_n,
  input  tpc_pkg::merge_in_t mrg_in,
  output logic               stall,
  output logic               out_valid,
  output tpc_pkg::tri_out_t  out_data
);

  logic second_r;
  logic second_nxt;
  logic out_valid_r;
  logic out_valid_nxt;
  tpc_pkg::tri_out_t out_data_r;
  tpc_pkg::tri_out_t out_data_nxt;

  function automatic tpc_pkg::tri_out_t pack_tri(tpc_pkg::tri_t t,
                                                 logic [tpc_pkg::COLOR_W-1:0] color,
                                                 logic last);
    tpc_pkg::tri_out_t o;
    o.out0_x = t[0][0];
    o.out0_y = t[0][1];
    o.out0_z = t[0][2];
    o.out1_x = t[1][0];
    o.out1_y = t[1][1];
    o.out1_z = t[1][2];
    o.out2_x = t[2][0];
    o.out2_y = t[2][1];
    o.out2_z = t[2][2];
    o.out_color = color;
    o.last_of_run = last;
    return o;
  endfunction

  // Next-state logic for the second half of a quad.
  always_comb begin
    stall = mrg_in.valid && (mrg_in.side.ccase == tpc_pkg::CLIP_TWO) && !second_r;
    second_nxt = stall;
  end

  // Triangle selection for the output register.
  always_comb begin
    tpc_pkg::tri_t t;
    logic last;
    t    = mrg_in.side.sv;
    last = 1'b1;
    case (mrg_in.side.ccase)
      tpc_pkg::CLIP_ONE: begin
        t[1] = mrg_in.xa;
        t[2] = mrg_in.xb;
      end
      tpc_pkg::CLIP_TWO: begin
        if (second_r) begin
          t[0] = mrg_in.side.sv[1];
          t[1] = mrg_in.xa;
          t[2] = mrg_in.xb;
        end else begin
          t[2] = mrg_in.xa;
          last = 1'b0;
        end
      end
      default: begin
        t = mrg_in.side.sv;
      end
    endcase
    out_valid_nxt = mrg_in.valid;
    out_data_nxt  = pack_tri(t, mrg_in.side.color, last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      second_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      second_r    <= second_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/triangle_plane_clipper.sv
// Top level of the triangle plane clipper: config registers, distances, lanes, merge.
// Depends on tpc_pkg, tpc_lane and tpc_merge.
//
//   port group   direction  handshake              payload
//   in_          input      start / busy           in_data (tri_in_t)
//   out_         output     out_valid strobe       out_data (tri_out_t)
//   cfg_         input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A triangle is taken each clock while busy is low; its first result passes the
// product, distance and setup stages, the division lanes and the merge register.
// A triangle clipped to a quad gives two results on consecutive cycles and
// raises busy for one cycle, holding the whole pipeline for that cycle.
// Reset is synchronous and active low; it clears valid flags and resets the plane registers.
// The receiver cannot stall; results are strobed for one cycle each.
module triangle_plane_clipper (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  tpc_pkg::tri_in_t                   in_data,
  output logic                               out_valid,
  output tpc_pkg::tri_out_t                  out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tpc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // Configuration registers.
  tpc_pkg::coord_t pt_r  [3];
  tpc_pkg::norm_t  nrm_r [3];
  tpc_pkg::prod_t  pd_r  [3];

  // Stage 1: products, stage 2: distances, stage 3: sorting and lane setup.
  logic            s1_valid_r;
  tpc_pkg::tri_t   s1_v_r;
  logic [tpc_pkg::COLOR_W-1:0] s1_color_r;
  tpc_pkg::prod_t  s1_p_r [3][3];
  logic            s2_valid_r;
  tpc_pkg::tri_t   s2_v_r;
  logic [tpc_pkg::COLOR_W-1:0] s2_color_r;
  tpc_pkg::dist_t  s2_d_r [3];
  logic            s3_valid_r;
  logic            s3_valid_nxt;
  tpc_pkg::side_t  s3_side_r;
  tpc_pkg::side_t  s3_side_nxt;
  tpc_pkg::lane_in_t lane_in_r   [2][3];
  tpc_pkg::lane_in_t lane_in_nxt [2][3];

  // Side pipe that keeps pace with the lanes.
  logic            side_valid_r [tpc_pkg::LANE_LAT];
  tpc_pkg::side_t  side_r       [tpc_pkg::LANE_LAT];

  tpc_pkg::tri_t   vin;
  tpc_pkg::coord_t lane_out [2][3];
  tpc_pkg::merge_in_t mrg_in;
  logic            stall;
  logic            en;
  logic            accept;

  assign cfg_ready = 1'b1;
  assign en        = !stall;
  assign busy      = stall;
  assign accept    = start && !busy;

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_r[0]  <= '0;
      pt_r[1]  <= '0;
      pt_r[2]  <= tpc_pkg::POINT_Z_RST;
      nrm_r[0] <= '0;
      nrm_r[1] <= '0;
      nrm_r[2] <= tpc_pkg::NORMAL_Z_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tpc_pkg::REG_POINT_X:  pt_r[0]  <= cfg_data[tpc_pkg::COORD_W-1:0];
        tpc_pkg::REG_POINT_Y:  pt_r[1]  <= cfg_data[tpc_pkg::COORD_W-1:0];
        tpc_pkg::REG_POINT_Z:  pt_r[2]  <= cfg_data[tpc_pkg::COORD_W-1:0];
        tpc_pkg::REG_NORMAL_X: nrm_r[0] <= cfg_data[tpc_pkg::NORM_W-1:0];
        tpc_pkg::REG_NORMAL_Y: nrm_r[1] <= cfg_data[tpc_pkg::NORM_W-1:0];
        tpc_pkg::REG_NORMAL_Z: nrm_r[2] <= cfg_data[tpc_pkg::NORM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Plane offset products, refreshed every cycle.
  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      pd_r[c] <= $signed(nrm_r[c]) * $signed(pt_r[c]);
    end
  end

  // Unpack the incoming triangle.
  always_comb begin
    vin[0][0] = in_data.vert0_x;
    vin[0][1] = in_data.vert0_y;
    vin[0][2] = in_data.vert0_z;
    vin[1][0] = in_data.vert1_x;
    vin[1][1] = in_data.vert1_y;
    vin[1][2] = in_data.vert1_z;
    vin[2][0] = in_data.vert2_x;
    vin[2][1] = in_data.vert2_y;
    vin[2][2] = in_data.vert2_z;
  end

  function automatic tpc_pkg::vec_t pick_v(tpc_pkg::tri_t v, logic [1:0] i);
    return (i == 2'd0) ? v[0] : ((i == 2'd1) ? v[1] : v[2]);
  endfunction

  function automatic tpc_pkg::dist_t pick_d(tpc_pkg::dist_t d0, tpc_pkg::dist_t d1,
                                            tpc_pkg::dist_t d2, logic [1:0] i);
    return (i == 2'd0) ? d0 : ((i == 2'd1) ? d1 : d2);
  endfunction

  function automatic tpc_pkg::lane_in_t mk_lane(tpc_pkg::coord_t a, tpc_pkg::coord_t b,
                                                tpc_pkg::dist_t da, tpc_pkg::dist_t db);
    tpc_pkg::lane_in_t l;
    logic signed [tpc_pkg::MAG_W-1:0] delta;
    tpc_pkg::dist_t den;
    delta = tpc_pkg::MAG_W'(b) - tpc_pkg::MAG_W'(a);
    den   = da - db;
    l.a   = a;
    l.neg = delta[tpc_pkg::MAG_W-1];
    l.mag = l.neg ? tpc_pkg::MAG_W'(-delta) : tpc_pkg::MAG_W'(delta);
    l.da  = tpc_pkg::DEN_W'(da);
    l.den = tpc_pkg::DEN_W'(den);
    return l;
  endfunction

  // Sort vertices inside-first and set up both crossings on three lanes each.
  always_comb begin
    logic [2:0] mask;
    logic [1:0] i0;
    logic [1:0] i1;
    logic [1:0] i2;
    tpc_pkg::clip_case_t cc;
    tpc_pkg::dist_t sd [3];
    tpc_pkg::vec_t  pa_a;
    tpc_pkg::vec_t  pa_b;
    tpc_pkg::vec_t  pb_a;
    tpc_pkg::dist_t da_a;
    tpc_pkg::dist_t db_a;
    tpc_pkg::dist_t da_b;
    for (int i = 0; i < 3; i++) begin
      mask[i] = !s2_d_r[i][tpc_pkg::DIST_W-1];
    end
    i0 = 2'd0;
    i1 = 2'd1;
    i2 = 2'd2;
    case (mask)
      3'b001: cc = tpc_pkg::CLIP_ONE;
      3'b010: begin
        cc = tpc_pkg::CLIP_ONE;
        i0 = 2'd1;
        i1 = 2'd0;
      end
      3'b100: begin
        cc = tpc_pkg::CLIP_ONE;
        i0 = 2'd2;
        i1 = 2'd0;
        i2 = 2'd1;
      end
      3'b011: cc = tpc_pkg::CLIP_TWO;
      3'b101: begin
        cc = tpc_pkg::CLIP_TWO;
        i1 = 2'd2;
        i2 = 2'd1;
      end
      3'b110: begin
        cc = tpc_pkg::CLIP_TWO;
        i0 = 2'd1;
        i1 = 2'd2;
        i2 = 2'd0;
      end
      3'b111: cc = tpc_pkg::CLIP_ALL;
      default: cc = tpc_pkg::CLIP_NONE;
    endcase
    s3_side_nxt.ccase = cc;
    s3_side_nxt.color = s2_color_r;
    s3_side_nxt.sv[0] = pick_v(s2_v_r, i0);
    s3_side_nxt.sv[1] = pick_v(s2_v_r, i1);
    s3_side_nxt.sv[2] = pick_v(s2_v_r, i2);
    sd[0] = pick_d(s2_d_r[0], s2_d_r[1], s2_d_r[2], i0);
    sd[1] = pick_d(s2_d_r[0], s2_d_r[1], s2_d_r[2], i1);
    sd[2] = pick_d(s2_d_r[0], s2_d_r[1], s2_d_r[2], i2);
    s3_valid_nxt = s2_valid_r && (cc != tpc_pkg::CLIP_NONE);
    // Crossing A runs from the first inside vertex to the first outside one.
    pa_a = s3_side_nxt.sv[0];
    da_a = sd[0];
    pa_b = (cc == tpc_pkg::CLIP_ONE) ? s3_side_nxt.sv[1] : s3_side_nxt.sv[2];
    db_a = (cc == tpc_pkg::CLIP_ONE) ? sd[1] : sd[2];
    // Crossing B ends at the last sorted vertex.
    pb_a = (cc == tpc_pkg::CLIP_ONE) ? s3_side_nxt.sv[0] : s3_side_nxt.sv[1];
    da_b = (cc == tpc_pkg::CLIP_ONE) ? sd[0] : sd[1];
    for (int c = 0; c < 3; c++) begin
      lane_in_nxt[0][c] = mk_lane(pa_a[c], pa_b[c], da_a, db_a);
      lane_in_nxt[1][c] = mk_lane(pb_a[c], s3_side_nxt.sv[2][c], da_b, sd[2]);
    end
  end

  // Valid flags of the pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      for (int k = 0; k < tpc_pkg::LANE_LAT; k++) begin
        side_valid_r[k] <= 1'b0;
      end
    end else if (en) begin
      s1_valid_r <= accept;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s3_valid_nxt;
      side_valid_r[0] <= s3_valid_r;
      for (int k = 1; k < tpc_pkg::LANE_LAT; k++) begin
        side_valid_r[k] <= side_valid_r[k-1];
      end
    end
  end

  // Payload of the pipeline.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_v_r     <= vin;
      s1_color_r <= in_data.tri_color;
      for (int i = 0; i < 3; i++) begin
        for (int c = 0; c < 3; c++) begin
          s1_p_r[i][c] <= $signed(nrm_r[c]) * $signed(vin[i][c]);
        end
      end
      s2_v_r     <= s1_v_r;
      s2_color_r <= s1_color_r;
      for (int i = 0; i < 3; i++) begin
        s2_d_r[i] <= tpc_pkg::DIST_W'(s1_p_r[i][0]) + tpc_pkg::DIST_W'(s1_p_r[i][1]) +
                     tpc_pkg::DIST_W'(s1_p_r[i][2]) - tpc_pkg::DIST_W'(pd_r[0]) -
                     tpc_pkg::DIST_W'(pd_r[1]) - tpc_pkg::DIST_W'(pd_r[2]);
      end
      s3_side_r <= s3_side_nxt;
      for (int x = 0; x < 2; x++) begin
        for (int c = 0; c < 3; c++) begin
          lane_in_r[x][c] <= lane_in_nxt[x][c];
        end
      end
      side_r[0] <= s3_side_r;
      for (int k = 1; k < tpc_pkg::LANE_LAT; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // Six division lanes: two crossings by three coordinates.
  for (genvar x = 0; x < 2; x++) begin : g_cross
    for (genvar c = 0; c < 3; c++) begin : g_coord
      tpc_lane u_lane (
        .clk     (clk),
        .en      (en),
        .lane_in (lane_in_r[x][c]),
        .coord   (lane_out[x][c])
      );
    end
  end

  always_comb begin
    mrg_in.valid = side_valid_r[tpc_pkg::LANE_LAT-1];
    mrg_in.side  = side_r[tpc_pkg::LANE_LAT-1];
    for (int c = 0; c < 3; c++) begin
      mrg_in.xa[c] = lane_out[0][c];
      mrg_in.xb[c] = lane_out[1][c];
    end
  end

  tpc_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .mrg_in    (mrg_in),
    .stall     (stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // A hold lasts exactly one cycle.
  assert property (@(posedge clk) disable iff (!rst_n) busy |=> !busy)
    else $error("busy held for more than one cycle");

  // A hold emits the first half of a quad next.
  assert property (@(posedge clk) disable iff (!rst_n)
                   busy |=> (out_valid && !out_data.last_of_run))
    else $error("hold without a first quad triangle");

  // The first half of a quad is always followed by the second.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (out_valid && !out_data.last_of_run) |=>
                   (out_valid && out_data.last_of_run))
    else $error("quad second triangle missing");

endmodule

>>> sim/triangle_plane_clipper_tb.sv
// Self-checking testbench for triangle_plane_clipper: directed and random triangles
// against an in-bench clipping predictor. Depends on tpc_pkg and the clipper RTL.
`timescale 1ns / 1ps

module triangle_plane_clipper_tb;

  localparam int HALF_PERIOD = 4;
  localparam int DRAIN_CYCLES = 48;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  tpc_pkg::tri_in_t in_data = '0;
  logic out_valid;
  tpc_pkg::tri_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [tpc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [tpc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow of the plane registers and the expected clipped triangles.
  tpc_pkg::coord_t plane_pt[3];
  tpc_pkg::norm_t plane_nrm[3];
  tpc_pkg::tri_out_t clipped_q[$];
  int error_count = 0;
  int sender_idle_pct = 0;

  triangle_plane_clipper u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Plane crossing on edge a (inside) to b (outside), rounded half away from a.
  function automatic tpc_pkg::vec_t plane_cross(tpc_pkg::vec_t a, tpc_pkg::vec_t b,
                                                longint da, longint db);
    tpc_pkg::vec_t x;
    longint delta;
    logic [127:0] mag, num, den2, q;
    for (int j = 0; j < 3; j++) begin
      delta = longint'(b[j]) - longint'(a[j]);
      mag = (delta < 0) ? 128'(-delta) : 128'(delta);
      num = mag * 128'(da) * 2 + 128'(da - db);
      den2 = 128'(da - db) * 2;
      q = num / den2;
      x[j] = (delta < 0) ? tpc_pkg::coord_t'(longint'(a[j]) - longint'(q[63:0]))
                         : tpc_pkg::coord_t'(longint'(a[j]) + longint'(q[63:0]));
    end
    return x;
  endfunction

  function automatic void push_clipped(tpc_pkg::vec_t a, tpc_pkg::vec_t b,
                                       tpc_pkg::vec_t c,
                                       logic [tpc_pkg::COLOR_W-1:0] color, logic last);
    tpc_pkg::tri_out_t r;
    r.out0_x = a[0]; r.out0_y = a[1]; r.out0_z = a[2];
    r.out1_x = b[0]; r.out1_y = b[1]; r.out1_z = b[2];
    r.out2_x = c[0]; r.out2_y = c[1]; r.out2_z = c[2];
    r.out_color = color;
    r.last_of_run = last;
    clipped_q = {clipped_q, r};
  endfunction

  // Classify vertices by signed distance and queue the triangles they yield.
  function automatic void predict_clip(tpc_pkg::tri_in_t t);
    tpc_pkg::vec_t v[3];
    longint nrm[3], pd, sdist[3];
    int ins[3], outs[3];
    int n_in, n_out;
    tpc_pkg::vec_t xa, xb;
    v[0] = '{t.vert0_z, t.vert0_y, t.vert0_x};
    v[1] = '{t.vert1_z, t.vert1_y, t.vert1_x};
    v[2] = '{t.vert2_z, t.vert2_y, t.vert2_x};
    pd = 0;
    n_in = 0;
    n_out = 0;
    for (int j = 0; j < 3; j++) begin
      nrm[j] = longint'(plane_nrm[j]);
      pd += nrm[j] * longint'(plane_pt[j]);
    end
    for (int i = 0; i < 3; i++) begin
      sdist[i] = -pd;
      for (int j = 0; j < 3; j++) sdist[i] += nrm[j] * longint'(v[i][j]);
      if (sdist[i] >= 0) begin
        ins[n_in] = i;
        n_in++;
      end else begin
        outs[n_out] = i;
        n_out++;
      end
    end
    case (n_in)
      3: push_clipped(v[0], v[1], v[2], t.tri_color, 1'b1);
      1: begin
        xa = plane_cross(v[ins[0]], v[outs[0]], sdist[ins[0]], sdist[outs[0]]);
        xb = plane_cross(v[ins[0]], v[outs[1]], sdist[ins[0]], sdist[outs[1]]);
        push_clipped(v[ins[0]], xa, xb, t.tri_color, 1'b1);
      end
      2: begin
        xa = plane_cross(v[ins[0]], v[outs[0]], sdist[ins[0]], sdist[outs[0]]);
        xb = plane_cross(v[ins[1]], v[outs[0]], sdist[ins[1]], sdist[outs[0]]);
        push_clipped(v[ins[0]], v[ins[1]], xa, t.tri_color, 1'b0);
        push_clipped(v[ins[1]], xa, xb, t.tri_color, 1'b1);
      end
      default: ;
    endcase
  endfunction

  function automatic tpc_pkg::tri_in_t make_tri(
      tpc_pkg::coord_t ax, tpc_pkg::coord_t ay, tpc_pkg::coord_t az,
      tpc_pkg::coord_t bx, tpc_pkg::coord_t by, tpc_pkg::coord_t bz,
      tpc_pkg::coord_t cx, tpc_pkg::coord_t cy, tpc_pkg::coord_t cz,
      logic [tpc_pkg::COLOR_W-1:0] color);
    tpc_pkg::tri_in_t t;
    t = '{ax, ay, az, bx, by, bz, cx, cy, cz, color};
    return t;
  endfunction

  function automatic tpc_pkg::coord_t rand_coord();
    case ($urandom_range(3))
      0: return tpc_pkg::coord_t'($urandom);
      1: return tpc_pkg::coord_t'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
      2: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return tpc_pkg::coord_t'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
    endcase
  endfunction

  function automatic tpc_pkg::tri_in_t rand_tri();
    return make_tri(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                    rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                    rand_coord(), tpc_pkg::COLOR_W'($urandom));
  endfunction

  // Send one triangle; returns at the accepting edge with start still high.
  task automatic send_tri(tpc_pkg::tri_in_t t);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (busy);
    predict_clip(t);
  endtask

  // Stop sending and wait until every expected triangle has come out.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (clipped_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(tpc_pkg::cfg_reg_t idx, logic [tpc_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= tpc_pkg::REG_POINT_Z) plane_pt[idx] = tpc_pkg::coord_t'(value);
    else plane_nrm[idx - tpc_pkg::REG_NORMAL_X] = tpc_pkg::norm_t'(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_plane(tpc_pkg::coord_t px, tpc_pkg::coord_t py, tpc_pkg::coord_t pz,
                           int nx, int ny, int nz);
    write_reg(tpc_pkg::REG_POINT_X, px);
    write_reg(tpc_pkg::REG_POINT_Y, py);
    write_reg(tpc_pkg::REG_POINT_Z, pz);
    write_reg(tpc_pkg::REG_NORMAL_X, nx);
    write_reg(tpc_pkg::REG_NORMAL_Y, ny);
    write_reg(tpc_pkg::REG_NORMAL_Z, nz);
  endtask

  // Reset plane z = 0.1 facing +z: every inside/outside split plus extremes.
  task automatic test_reset_plane();
    send_tri(make_tri(0, 0, 32'sh10000, 1, 2, 32'sh20000, 3, 4, 6554, 24'h000000));
    send_tri(make_tri(0, 0, -1, 5, 6, -7, 8, 9, 6553, 24'hffffff));
    send_tri(make_tri(10, 20, 32'sh40000, 30, 40, -32'sh40000, 50, 60, -32'sh10000,
                      24'h123456));
    send_tri(make_tri(-32'sh10000, 7, -32'sh30000, 32'sh20000, 3, 32'sh50000,
                      9, 9, 32'sh30000, 24'habcdef));
    send_tri(make_tri(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                      32'sh7fffffff, 32'sh80000000, 0, 0, 6555, 24'h800001));
    send_tri(make_tri(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                      32'sh80000000, 32'sh80000000, 1, -1, 32'sh80000000, 24'h7ffffe));
    send_tri(make_tri(0, 0, 6554, 0, 0, 6553, 0, 0, 6554, 24'h0f0f0f));
    send_tri(make_tri(0, 0, -5, 0, 0, 6554, 0, 0, 6553, 24'hf0f0f0));
  endtask

  // Extreme and degenerate planes, including a zero and an unnormalized normal.
  task automatic test_plane_extremes();
    drain();
    set_plane(0, 0, 0, 0, 0, 0);
    send_tri(rand_tri());
    send_tri(make_tri(32'sh80000000, 0, 0, 0, 32'sh7fffffff, 0, 0, 0, 0, 24'h1));
    drain();
    set_plane(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, -65536, 65536, -65536);
    repeat (5) send_tri(rand_tri());
    drain();
    set_plane(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 18'h1ffff, 18'h20000, 65536);
    repeat (5) send_tri(rand_tri());
    drain();
    set_plane(32'sh10000, -32'sh20000, 0, 65536, 0, 0);
    send_tri(make_tri(32'sh10000, 0, 0, 32'sh8000, 1, 1, 32'sh30000, 2, 2, 24'h55aa55));
    send_tri(make_tri(-5, 3, 3, 32'sh20000, 4, 4, 32'sh7fffffff, 5, 5, 24'haa55aa));
  endtask

  // Random triangles in phases of sender idling, with a random plane per phase.
  task automatic test_random_clip();
    int pct[4] = '{0, 85, 0, 9};
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      set_plane(rand_coord(), rand_coord(), rand_coord(),
                $urandom_range(0, 1 << 18) - (1 << 17),
                $urandom_range(0, 1 << 17) - (1 << 16),
                $urandom_range(0, 1 << 17) - (1 << 16));
      sender_idle_pct = pct[ph];
      repeat (280) send_tri(rand_tri());
    end
    sender_idle_pct = 0;
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      error_count++;
    end
  endtask

  // Compare each strobed triangle with the oldest expected one.
  always @(posedge clk) begin
    tpc_pkg::tri_out_t e;
    if (rst_n && out_valid) begin
      if (clipped_q.size() == 0) begin
        $error("unexpected output transaction");
        error_count++;
      end else begin
        e = clipped_q.pop_front();
        check_field("out0_x", e.out0_x, out_data.out0_x);
        check_field("out0_y", e.out0_y, out_data.out0_y);
        check_field("out0_z", e.out0_z, out_data.out0_z);
        check_field("out1_x", e.out1_x, out_data.out1_x);
        check_field("out1_y", e.out1_y, out_data.out1_y);
        check_field("out1_z", e.out1_z, out_data.out1_z);
        check_field("out2_x", e.out2_x, out_data.out2_x);
        check_field("out2_y", e.out2_y, out_data.out2_y);
        check_field("out2_z", e.out2_z, out_data.out2_z);
        check_field("out_color", 32'(e.out_color), 32'(out_data.out_color));
        check_field("last_of_run", 32'(e.last_of_run), 32'(out_data.last_of_run));
      end
    end
  end

  initial begin
    plane_pt = '{0, 0, 6554};
    plane_nrm = '{0, 0, 65536};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_plane();
    test_plane_extremes();
    test_random_clip();
    drain();
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hard stop in case the pipeline hangs.
  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
